// ===== rtl/npsm_pkg.sv =====
// package: payload types, codes and constants of the shape matcher
`timescale 1ns / 1ps
`default_nettype none
package npsm_pkg;

  localparam int LEN_W  = 9;
  localparam int DIST_W = 48;

  localparam logic [1:0] MODE_LOAD  = 2'd0;
  localparam logic [1:0] MODE_QUERY = 2'd1;
  localparam logic [1:0] MODE_CLEAR = 2'd2;

  localparam logic [2:0] ST_MATCH = 3'd0;
  localparam logic [2:0] ST_EMPTY = 3'd1;
  localparam logic [2:0] ST_LEN   = 3'd2;
  localparam logic [2:0] ST_RANGE = 3'd3;
  localparam logic [2:0] ST_FULL  = 3'd4;

  localparam logic REG_FILTER   = 1'b0;
  localparam logic REG_NEIGHBOR = 1'b1;

  localparam logic [6:0] FILTER_RESET   = 7'd15;
  localparam logic [4:0] NEIGHBOR_RESET = 5'd4;

  localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

  // floor(v / 100) = (v * RECIP_M) >> RECIP_SH for v below 2^17
  localparam logic [17:0] RECIP_M  = 18'd167773;
  localparam int          RECIP_SH = 24;

  typedef struct packed {
    logic [1:0]         mode;
    logic [9:0]         class_id;
    logic signed [15:0] point_x;
    logic signed [15:0] point_y;
    logic signed [15:0] sin_feature;
    logic signed [15:0] cos_feature;
    logic               last;
  } in_t;

  typedef struct packed {
    logic [2:0]        status;
    logic [2:0]        rank;
    logic [9:0]        class_id_res;
    logic [DIST_W-1:0] distance;
    logic              last_res;
  } out_t;

  typedef struct packed {
    logic              taken;
    logic [9:0]        cls;
    logic [LEN_W-1:0]  len;
    logic [DIST_W-1:0] sum;
  } entry_t;

  typedef struct packed {
    logic clr;
    logic shift;
  } ring_ctl_t;

  typedef enum logic [2:0] {
    S_IDLE, S_FEAT, S_SWEEP, S_KEPT, S_RANGE, S_SCAN, S_PICK, S_EMIT
  } state_t;

  typedef enum logic [2:0] {
    F_IDLE, F_MAG, F_SQRT, F_NORM, F_DIV
  } feat_state_t;

  function automatic out_t err_word(input logic [2:0] st);
    out_t w;
    w.status       = st;
    w.rank         = 3'd0;
    w.class_id_res = 10'd0;
    w.distance     = '0;
    w.last_res     = 1'b1;
    return w;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/npsm_ram.sv =====
// generic single write port ram with registered read
`timescale 1ns / 1ps
`default_nettype none
module npsm_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== rtl/npsm_cell.sv =====
// one ring cell: holds a prototype's class, length, running sum and taken flag
`timescale 1ns / 1ps
`default_nettype none
module npsm_cell (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire npsm_pkg::ring_ctl_t ctl,
  input  wire logic                wr,
  input  wire logic [9:0]          wr_cls,
  input  wire logic [8:0]          wr_len,
  input  wire logic                take,
  input  wire npsm_pkg::entry_t    ent_in,
  output      npsm_pkg::entry_t    ent
);
  import npsm_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      ent <= '0;
    end else if (ctl.clr) begin
      ent.sum   <= '0;
      ent.taken <= 1'b0;
    end else if (wr) begin
      ent.cls   <= wr_cls;
      ent.len   <= wr_len;
      ent.sum   <= '0;
      ent.taken <= 1'b0;
    end else if (take) begin
      ent.taken <= 1'b1;
    end else if (ctl.shift) begin
      ent <= ent_in;
    end
  end
endmodule
`default_nettype wire

// ===== rtl/npsm_feat.sv =====
// direction features of a query point: magnitude, bitwise square root, two dividers
`timescale 1ns / 1ps
`default_nettype none
module npsm_feat #(
  parameter int NORMALIZED_SIZE = 10
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire logic               first,
  input  wire logic signed [15:0] x,
  input  wire logic signed [15:0] y,
  input  wire logic signed [15:0] px,
  input  wire logic signed [15:0] py,
  output      logic               done,
  output      logic signed [15:0] fs,
  output      logic signed [15:0] fc
);
  import npsm_pkg::*;

  localparam int SCALE = NORMALIZED_SIZE * 256;
  localparam int QB    = $clog2(SCALE + 1);
  localparam int NW    = QB + 20;

  feat_state_t state, state_next;

  logic signed [16:0] dx, dy;
  logic signed [33:0] sqx, sqy;
  logic [33:0]        v, r, bitv, t;
  logic [4:0]         k;
  logic [17:0]        norm;
  logic signed [18:0] ns, nc;
  logic [NW-1:0]      rem_s, rem_c, den, dsh;
  logic [QB-1:0]      q_s, q_c;
  logic [3:0]         j;

  assign sqx  = dx * dx;
  assign sqy  = dy * dy;
  assign bitv = 34'd1 << {k, 1'b0};
  assign t    = r + bitv;
  assign ns   = $signed({1'b0, norm}) + 19'(dy);
  assign nc   = $signed({1'b0, norm}) + 19'(dx);
  assign dsh  = den << j;

  always_comb begin
    state_next = state;
    case (state)
      F_IDLE:  if (start) state_next = F_MAG;
      F_MAG:   state_next = F_SQRT;
      F_SQRT:  if (k == 5'd0) state_next = F_NORM;
      F_NORM:  state_next = F_DIV;
      F_DIV:   if (j == 4'd0) state_next = F_IDLE;
      default: state_next = F_IDLE;
    endcase
  end

  always_comb begin
    done = (state == F_DIV) && (j == 4'd0);
  end

  assign fs = 16'(q_s);
  assign fc = 16'(q_c);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      F_IDLE: begin
        if (start) begin
          dx <= first ? 17'(x) : 17'(x) - 17'(px);
          dy <= first ? 17'(y) : 17'(y) - 17'(py);
        end
      end
      F_MAG: begin
        v <= $unsigned(sqx) + $unsigned(sqy);
        r <= '0;
        k <= 5'd16;
      end
      F_SQRT: begin
        if (v >= t) begin
          v <= v - t;
          r <= (r >> 1) + bitv;
        end else begin
          r <= r >> 1;
        end
        k <= k - 5'd1;
      end
      F_NORM: begin
        rem_s <= NW'(SCALE) * NW'($unsigned(ns)) + NW'(norm);
        rem_c <= NW'(SCALE) * NW'($unsigned(nc)) + NW'(norm);
        den   <= NW'({norm, 1'b0});
        q_s   <= '0;
        q_c   <= '0;
        j     <= 4'(QB - 1);
      end
      F_DIV: begin
        if (rem_s >= dsh) begin
          rem_s <= rem_s - dsh;
          q_s   <= {q_s[QB-2:0], 1'b1};
        end else begin
          q_s   <= {q_s[QB-2:0], 1'b0};
        end
        if (rem_c >= dsh) begin
          rem_c <= rem_c - dsh;
          q_c   <= {q_c[QB-2:0], 1'b1};
        end else begin
          q_c   <= {q_c[QB-2:0], 1'b0};
        end
        j <= j - 4'd1;
      end
      default: ;
    endcase
    // norm is taken from the final square root step
    if (state == F_SQRT && k == 5'd0) begin
      norm <= ((v >= t) ? 18'((r >> 1) + bitv) : 18'(r >> 1)) + 18'd1;
    end
  end
endmodule
`default_nettype wire

// ===== rtl/nearest_prototype_shape_matcher.sv =====
// top level: prototype table, ring of distance cells, sweep and ranking control
//
//   port group  | direction | handshake
//   in_word     | in        | in_valid / in_ready
//   out_word    | out       | out_valid / out_ready
//   cfg_*       | in        | cfg_we, no wait
//
// load and clear words are handled in S_IDLE; a closing load on a full table also emits an error word
// a query word runs the feature unit, then sweeps the ring, one ring cell per cycle
// the closing query word then passes S_KEPT and S_RANGE, then a ring scan, S_PICK and S_EMIT
// for each ranked word; an empty table or a range error goes from S_RANGE straight to S_EMIT
// synchronous reset empties the table; no clearing pass is needed
// a stalled output word holds the ranking loop until it is taken
`timescale 1ns / 1ps
`default_nettype none
module nearest_prototype_shape_matcher #(
  parameter int MAX_PROTOTYPES  = 64,
  parameter int MAX_POINTS      = 64,
  parameter int NUM_CHOICES     = 5,
  parameter int NORMALIZED_SIZE = 10
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  output      logic            in_ready,
  input  wire npsm_pkg::in_t   in_word,
  output      logic            out_valid,
  input  wire logic            out_ready,
  output      npsm_pkg::out_t  out_word,
  input  wire logic            cfg_we,
  input  wire logic            cfg_index,
  input  wire logic [6:0]      cfg_data
);
  import npsm_pkg::*;

  localparam int N   = MAX_PROTOTYPES;
  localparam int PW  = (N > 1) ? $clog2(N) : 1;
  localparam int CW  = $clog2(N + 1);
  localparam int QW  = $clog2(MAX_POINTS + 2);
  localparam int LW  = $clog2(MAX_POINTS + 1);
  localparam int AW  = $clog2(N * MAX_POINTS);
  localparam int SW  = $clog2(N + 3);
  localparam int NW  = $clog2(NUM_CHOICES + 1);
  localparam int KW  = CW + 1;
  localparam int PRW = CW + 7;

  state_t state, state_next;

  logic [6:0]         fp;
  logic [4:0]         nc;
  logic [CW-1:0]      count;
  logic [LW-1:0]      load_idx;
  logic [QW-1:0]      qidx;
  logic signed [15:0] prev_x, prev_y, cur_x, cur_y;
  logic               cur_last;
  logic [SW-1:0]      sc;
  logic [PRW-1:0]     prod;
  logic [NW-1:0]      n_res, rank_cnt;
  logic [DIST_W-1:0]  best_sum;
  logic [9:0]         best_cls;
  logic [PW-1:0]      best_idx;
  logic               found, mismatch;
  out_t               em;
  logic               em_clr;

  logic               acc, out_free, is_load, ram_we, commit, take_en;
  ring_ctl_t          ctl;
  logic [AW-1:0]      waddr, raddr;
  logic [63:0]        rdata;
  logic               feat_done;
  logic signed [15:0] fs, fc;
  logic signed [16:0] e0, e1, e2, e3;
  logic signed [33:0] p0, p1, p2, p3;
  logic [33:0]        sq0, sq1, sq2, sq3;
  logic [35:0]        pd;
  logic [SW-1:0]      jsw;
  logic               upd, head_ok;
  logic [DIST_W:0]    acc_sum;
  logic [PRW+17:0]    km;
  logic [KW-1:0]      kept, cand;
  logic               range_err;
  logic [LW-1:0]      len_new;

  entry_t ents [N];
  entry_t head, tail;

  assign acc      = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == S_IDLE);
  assign is_load  = acc && (in_word.mode == MODE_LOAD) && (count < CW'(N));
  assign ram_we   = is_load && (load_idx < LW'(MAX_POINTS));
  assign commit   = is_load && in_word.last;
  assign len_new  = ram_we ? load_idx + LW'(1) : load_idx;
  assign take_en  = (state == S_PICK) && !mismatch;

  assign waddr = AW'(count[PW-1:0]) * AW'(MAX_POINTS) + AW'(load_idx);
  assign raddr = AW'((sc < SW'(N)) ? sc[PW-1:0] : '0) * AW'(MAX_POINTS)
               + AW'((qidx < QW'(MAX_POINTS)) ? qidx : '0);

  npsm_ram #(.WIDTH(64), .DEPTH(N * MAX_POINTS)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (waddr),
    .wdata ({in_word.cos_feature, in_word.sin_feature, in_word.point_y, in_word.point_x}),
    .raddr (raddr),
    .rdata (rdata)
  );

  npsm_feat #(.NORMALIZED_SIZE(NORMALIZED_SIZE)) u_feat (
    .clk   (clk),
    .rst   (rst),
    .start (acc && (in_word.mode == MODE_QUERY)),
    .first (qidx == '0),
    .x     (in_word.point_x),
    .y     (in_word.point_y),
    .px    (prev_x),
    .py    (prev_y),
    .done  (feat_done),
    .fs    (fs),
    .fc    (fc)
  );

  // ring of cells, head at cell 0, tail fed back from the update logic
  genvar i;
  generate
    for (i = 0; i < N; i++) begin : g_cell
      npsm_cell u_cell (
        .clk    (clk),
        .rst    (rst),
        .ctl    (ctl),
        .wr     (commit && (count == CW'(i))),
        .wr_cls (in_word.class_id),
        .wr_len (LEN_W'(len_new)),
        .take   (take_en && (best_idx == PW'(i))),
        .ent_in ((i == N - 1) ? tail : ents[(i + 1) % N]),
        .ent    (ents[i])
      );
    end
  endgenerate

  assign head = ents[0];

  // point distance pipeline: read, square, sum
  assign e0 = 17'(cur_x) - 17'($signed(rdata[15:0]));
  assign e1 = 17'(cur_y) - 17'($signed(rdata[31:16]));
  assign e2 = 17'(fs) - 17'($signed(rdata[47:32]));
  assign e3 = 17'(fc) - 17'($signed(rdata[63:48]));
  assign p0 = e0 * e0;
  assign p1 = e1 * e1;
  assign p2 = e2 * e2;
  assign p3 = e3 * e3;

  always_ff @(posedge clk) begin
    sq0 <= $unsigned(p0);
    sq1 <= $unsigned(p1);
    sq2 <= $unsigned(p2);
    sq3 <= $unsigned(p3);
    pd  <= 36'(sq0) + 36'(sq1) + 36'(sq2) + 36'(sq3);
  end

  assign jsw     = sc - SW'(3);
  assign head_ok = (10'(qidx) < 10'(head.len)) && (qidx < QW'(MAX_POINTS));
  assign upd     = (state == S_SWEEP) && (jsw < SW'(count)) && head_ok;
  assign acc_sum = {1'b0, head.sum} + (DIST_W + 1)'(pd);

  always_comb begin
    tail = head;
    if (upd) begin
      tail.sum = acc_sum[DIST_W] ? DIST_MAX : acc_sum[DIST_W-1:0];
    end
  end

  // kept = filter_percent * count / 100
  assign km        = (PRW + 18)'(prod) * (PRW + 18)'(RECIP_M);
  assign kept      = KW'(km >> RECIP_SH);
  assign range_err = (fp != 7'd0) && (kept != '0) && (16'(kept) < 16'(nc));
  assign cand      = ((fp != 7'd0) && (kept != '0) && (16'(kept) < 16'(count)))
                   ? kept : KW'(count);

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (acc) begin
          if (in_word.mode == MODE_QUERY) begin
            state_next = S_FEAT;
          end else if (in_word.mode == MODE_LOAD && count >= CW'(N) && in_word.last) begin
            state_next = S_EMIT;
          end
        end
      end
      S_FEAT:  if (feat_done) state_next = S_SWEEP;
      S_SWEEP: if (sc == SW'(N + 2)) state_next = cur_last ? S_KEPT : S_IDLE;
      S_KEPT:  state_next = S_RANGE;
      S_RANGE: state_next = (count == '0 || range_err) ? S_EMIT : S_SCAN;
      S_SCAN:  if (sc == SW'(N - 1)) state_next = S_PICK;
      S_PICK:  state_next = S_EMIT;
      S_EMIT:  if (out_free) state_next = em.last_res ? S_IDLE : S_SCAN;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    ctl.shift = ((state == S_SWEEP) && (sc >= SW'(3))) || (state == S_SCAN);
    ctl.clr   = (acc && in_word.mode == MODE_CLEAR)
              || ((state == S_EMIT) && out_free && em.last_res && em_clr);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fp        <= FILTER_RESET;
      nc        <= NEIGHBOR_RESET;
      count     <= '0;
      load_idx  <= '0;
      qidx      <= '0;
      prev_x    <= '0;
      prev_y    <= '0;
      sc        <= '0;
      out_valid <= 1'b0;
      found     <= 1'b0;
      mismatch  <= 1'b0;
      em_clr    <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_FILTER:   fp <= cfg_data;
          REG_NEIGHBOR: nc <= cfg_data[4:0];
          default: ;
        endcase
      end
      if (out_valid && out_ready && state != S_EMIT) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (acc) begin
            case (in_word.mode)
              MODE_LOAD: begin
                if (count >= CW'(N)) begin
                  if (in_word.last) begin
                    load_idx <= '0;
                    em       <= err_word(ST_FULL);
                    em_clr   <= 1'b0;
                  end
                end else if (in_word.last) begin
                  count    <= count + CW'(1);
                  load_idx <= '0;
                end else if (ram_we) begin
                  load_idx <= load_idx + LW'(1);
                end
              end
              MODE_QUERY: begin
                cur_x    <= in_word.point_x;
                cur_y    <= in_word.point_y;
                cur_last <= in_word.last;
              end
              MODE_CLEAR: begin
                count    <= '0;
                load_idx <= '0;
                qidx     <= '0;
                prev_x   <= '0;
                prev_y   <= '0;
              end
              default: ;
            endcase
          end
        end
        S_SWEEP: begin
          if (sc == SW'(N + 2)) begin
            sc     <= '0;
            prev_x <= cur_x;
            prev_y <= cur_y;
            if (qidx < QW'(MAX_POINTS + 1)) begin
              qidx <= qidx + QW'(1);
            end
          end else begin
            sc <= sc + SW'(1);
          end
        end
        S_KEPT: begin
          prod <= PRW'(fp) * PRW'(count);
        end
        S_RANGE: begin
          em_clr   <= 1'b1;
          sc       <= '0;
          found    <= 1'b0;
          mismatch <= 1'b0;
          rank_cnt <= '0;
          n_res    <= (16'(cand) < 16'(NUM_CHOICES)) ? NW'(cand) : NW'(NUM_CHOICES);
          if (count == '0) begin
            em <= err_word(ST_EMPTY);
          end else if (range_err) begin
            em <= err_word(ST_RANGE);
          end
        end
        S_SCAN: begin
          sc <= (sc == SW'(N - 1)) ? '0 : sc + SW'(1);
          if (sc < SW'(count)) begin
            if (10'(head.len) != 10'(qidx)) begin
              mismatch <= 1'b1;
            end
            if (!head.taken && (!found || head.sum < best_sum)) begin
              best_sum <= head.sum;
              best_cls <= head.cls;
              best_idx <= sc[PW-1:0];
              found    <= 1'b1;
            end
          end
        end
        S_PICK: begin
          if (mismatch) begin
            em <= err_word(ST_LEN);
          end else begin
            em.status       <= ST_MATCH;
            em.rank         <= 3'(rank_cnt);
            em.class_id_res <= best_cls;
            em.distance     <= best_sum;
            em.last_res     <= (NW'(rank_cnt + NW'(1)) == n_res);
            rank_cnt        <= rank_cnt + NW'(1);
          end
        end
        S_EMIT: begin
          if (out_free) begin
            out_valid <= 1'b1;
            out_word  <= em;
            found     <= 1'b0;
            if (em.last_res && em_clr) begin
              qidx   <= '0;
              prev_x <= '0;
              prev_y <= '0;
            end
          end
        end
        default: ;
      endcase
    end
  end
endmodule
`default_nettype wire

// ===== rtl/npsm_chk.sv =====
// port checker for the shape matcher and its bind
`timescale 1ns / 1ps
`default_nettype none
module npsm_chk (
  input wire logic           clk,
  input wire logic           rst,
  input wire logic           in_valid,
  input wire logic           in_ready,
  input wire npsm_pkg::in_t  in_word,
  input wire logic           out_valid,
  input wire logic           out_ready,
  input wire npsm_pkg::out_t out_word
);
  import npsm_pkg::*;

  // stalled word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_word))
    else $error("output word changed while stalled");

  // error words stand alone
  a_err_single: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_word.status != ST_MATCH |-> out_word.last_res && out_word.rank == 3'd0)
    else $error("error word not final");

  // query word keeps the block busy
  a_query_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && in_word.mode == MODE_QUERY |=> !in_ready)
    else $error("input taken during query work");

  // ranking continues after a non-final word
  a_rank_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !out_word.last_res |=> !in_ready || out_valid)
    else $error("input taken in the middle of a ranking");
endmodule

bind nearest_prototype_shape_matcher npsm_chk u_npsm_chk (.*);
`default_nettype wire
